### src/syncw_pkg.sv
package syncw_pkg;

    localparam int unsigned MAX_SYNC_BYTES_DEF = 8;
    localparam longint unsigned MAX_BUFFER_BITS_DEF = 65535;
    localparam int unsigned PATTERN_W = 64;
    localparam int unsigned LEN_W = 4;
    localparam int unsigned ERR_W = 7;
    localparam int unsigned CNT_W = 16;
    localparam int unsigned GROUP_BITS = 8;
    localparam int unsigned GROUP_SUM_W = 4;

    typedef enum logic [1:0] {
        CFG_SYNC_PATTERN = 2'd0,
        CFG_SYNC_LEN     = 2'd1,
        CFG_LSB_FIRST    = 2'd2,
        CFG_MAX_ERRORS   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic stream_bit;
        logic first_bit;
        logic last_bit;
    } item_t;

    typedef struct packed {
        logic             found;
        logic [CNT_W-1:0] end_position;
    } result_t;

    // per-transaction sideband carried alongside the mismatch tally
    typedef struct packed {
        logic             first_bit;
        logic             last_bit;
        logic             full;
        logic [CNT_W-1:0] position;
    } item_meta_t;

    // sync bit k lands on window bit len-1-k, newest bit in bit 0
    function automatic logic [PATTERN_W-1:0] expected_bits(
        input logic [PATTERN_W-1:0] pattern,
        input logic [ERR_W-1:0]     len_bits,
        input logic                 lsb
    );
        logic [PATTERN_W-1:0] w;
        logic [ERR_W-1:0]     k;
        logic [2:0]           b;
        w = '0;
        for (int i = 0; i < PATTERN_W; i++)
        begin
            if (ERR_W'(i) < len_bits)
            begin
                k = len_bits - ERR_W'(i) - ERR_W'(1);
                b = lsb ? k[2:0] : (3'd7 - k[2:0]);
                w[i] = pattern[{k[5:3], b}];
            end
        end
        return w;
    endfunction

endpackage

### src/syncw_cell.sv
module syncw_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  logic shift_in,
    input  logic clear,
    input  logic expected,
    input  logic in_use,
    output logic bit_q,
    output logic mismatch
);

    logic bit_reg;
    logic bit_next;
    logic mismatch_reg;
    logic mismatch_next;

    // buffer end leaves the window empty for the next transaction
    assign bit_next      = clear ? 1'b0 : shift_in;
    assign mismatch_next = (shift_in ^ expected) & in_use;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_reg <= 1'b0;
        end
        else if (load)
        begin
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mismatch_reg <= mismatch_next;
        end
    end

    assign bit_q    = bit_reg;
    assign mismatch = mismatch_reg;

endmodule

### src/syncw_tally.sv
module syncw_tally #(
    parameter int unsigned GROUPS = syncw_pkg::MAX_SYNC_BYTES_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     advance,
    input  logic                                     valid,
    input  syncw_pkg::item_meta_t                    meta,
    input  logic [GROUPS*syncw_pkg::GROUP_BITS-1:0]  mismatch,
    output logic                                     tally_valid,
    output syncw_pkg::item_meta_t                    tally_meta,
    output logic [syncw_pkg::ERR_W-1:0]              distance
);

    logic [syncw_pkg::GROUP_SUM_W-1:0] group_reg  [GROUPS];
    logic [syncw_pkg::GROUP_SUM_W-1:0] group_next [GROUPS];
    syncw_pkg::item_meta_t             meta_reg;
    logic                              valid_reg;
    logic [syncw_pkg::ERR_W-1:0]       total;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            group_next[g] = '0;
            for (int b = 0; b < syncw_pkg::GROUP_BITS; b++)
            begin
                group_next[g] = group_next[g]
                    + syncw_pkg::GROUP_SUM_W'(mismatch[g*syncw_pkg::GROUP_BITS + b]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && valid)
        begin
            group_reg <= group_next;
            meta_reg  <= meta;
        end
    end

    always_comb
    begin
        total = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            total = total + syncw_pkg::ERR_W'(group_reg[g]);
        end
    end

    assign tally_valid = valid_reg;
    assign tally_meta  = meta_reg;
    assign distance    = total;

endmodule

### src/syncword_hamming_detector_top.sv
// a transaction is registered in the window cells, then in the mismatch tally, then in the output register
// throughput: one bit per cycle, back to back; the window cells, the mismatch tally
// and the output register each hold one transaction and move on together
// a stalled result holds every stage and stalls the input in the same cycle
// reset: window, bit count, match flag and pipeline valids are cleared and the
// configuration returns to pattern 0, one byte, msb first, no errors allowed
module syncword_hamming_detector_top #(
    parameter int unsigned     MAX_SYNC_BYTES  = syncw_pkg::MAX_SYNC_BYTES_DEF,
    parameter longint unsigned MAX_BUFFER_BITS = syncw_pkg::MAX_BUFFER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  syncw_pkg::item_t                  item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output syncw_pkg::result_t                result,
    input  logic                              cfg_write,
    input  syncw_pkg::cfg_index_t             cfg_index,
    input  logic [syncw_pkg::PATTERN_W-1:0]   cfg_data
);

    localparam int unsigned WIN = syncw_pkg::GROUP_BITS * MAX_SYNC_BYTES;
    localparam logic [syncw_pkg::CNT_W-1:0] CNT_CAP =
        (MAX_BUFFER_BITS < 64'd65535) ? syncw_pkg::CNT_W'(MAX_BUFFER_BITS)
                                      : {syncw_pkg::CNT_W{1'b1}};

    // configuration
    logic [syncw_pkg::PATTERN_W-1:0] pattern_reg;
    logic [syncw_pkg::LEN_W-1:0]     len_reg;
    logic                            lsb_reg;
    logic [syncw_pkg::ERR_W-1:0]     max_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            len_reg     <= syncw_pkg::LEN_W'(1);
            lsb_reg     <= 1'b0;
            max_err_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                syncw_pkg::CFG_SYNC_PATTERN: pattern_reg <= cfg_data;
                syncw_pkg::CFG_SYNC_LEN:     len_reg     <= cfg_data[syncw_pkg::LEN_W-1:0];
                syncw_pkg::CFG_LSB_FIRST:    lsb_reg     <= cfg_data[0];
                syncw_pkg::CFG_MAX_ERRORS:   max_err_reg <= cfg_data[syncw_pkg::ERR_W-1:0];
                default:                     pattern_reg <= pattern_reg;
            endcase
        end
    end

    logic [syncw_pkg::LEN_W-1:0]     used_bytes;
    logic [syncw_pkg::ERR_W-1:0]     len_bits;
    logic [syncw_pkg::PATTERN_W-1:0] expected;

    always_comb
    begin
        if (len_reg == '0)
        begin
            used_bytes = syncw_pkg::LEN_W'(1);
        end
        else if (len_reg > syncw_pkg::LEN_W'(MAX_SYNC_BYTES))
        begin
            used_bytes = syncw_pkg::LEN_W'(MAX_SYNC_BYTES);
        end
        else
        begin
            used_bytes = len_reg;
        end
    end

    assign len_bits = {used_bytes, 3'b000};
    assign expected = syncw_pkg::expected_bits(pattern_reg, len_bits, lsb_reg);

    // handshake
    logic advance;
    logic accept;
    logic result_valid_reg;

    assign advance    = !result_valid_reg || !result_stall;
    assign accept     = item_valid && advance;
    assign item_stall = !advance;

    // bit count
    logic [syncw_pkg::CNT_W-1:0] count_reg;
    logic [syncw_pkg::CNT_W-1:0] count_base;
    logic [syncw_pkg::CNT_W-1:0] count_next;

    assign count_base = item.first_bit ? '0 : count_reg;
    assign count_next = (count_base < CNT_CAP) ? count_base + syncw_pkg::CNT_W'(1) : count_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= item.last_bit ? '0 : count_next;
        end
    end

    // window cells
    logic [WIN-1:0] window;
    logic [WIN-1:0] shift_in;
    logic [WIN-1:0] mismatch;

    assign shift_in[0] = item.stream_bit;

    genvar i;
    generate
        for (i = 0; i < WIN; i++)
        begin : g_cell
            if (i > 0)
            begin : g_link
                assign shift_in[i] = window[i-1] && !item.first_bit;
            end

            syncw_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .load     (accept),
                .shift_in (shift_in[i]),
                .clear    (item.last_bit),
                .expected (expected[i]),
                .in_use   (syncw_pkg::ERR_W'(i) < len_bits),
                .bit_q    (window[i]),
                .mismatch (mismatch[i])
            );
        end
    endgenerate

    // sideband for the cell stage
    logic                  stage1_valid_reg;
    syncw_pkg::item_meta_t stage1_meta_reg;
    syncw_pkg::item_meta_t stage1_meta_next;

    always_comb
    begin
        stage1_meta_next.first_bit = item.first_bit;
        stage1_meta_next.last_bit  = item.last_bit;
        stage1_meta_next.full      = count_next >= syncw_pkg::CNT_W'(len_bits);
        stage1_meta_next.position  = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            stage1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage1_meta_reg <= stage1_meta_next;
        end
    end

    // mismatch tally
    logic                        tally_valid;
    syncw_pkg::item_meta_t       tally_meta;
    logic [syncw_pkg::ERR_W-1:0] distance;

    syncw_tally #(
        .GROUPS (MAX_SYNC_BYTES)
    ) u_tally (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .valid       (stage1_valid_reg),
        .meta        (stage1_meta_reg),
        .mismatch    (mismatch),
        .tally_valid (tally_valid),
        .tally_meta  (tally_meta),
        .distance    (distance)
    );

    // decision and output register
    logic               done_reg;
    logic               done_next;
    logic               done_now;
    logic               match;
    logic               emit;
    syncw_pkg::result_t result_reg;
    syncw_pkg::result_t result_next;

    always_comb
    begin
        done_now  = tally_meta.first_bit ? 1'b0 : done_reg;
        match     = tally_meta.full && (distance <= max_err_reg);
        emit      = !done_now && (match || tally_meta.last_bit);
        done_next = tally_meta.last_bit ? 1'b0 : (done_now || match);
        result_next.found        = match;
        result_next.end_position = match ? tally_meta.position : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= tally_valid && emit;
            if (tally_valid)
            begin
                done_reg <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && tally_valid && emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### tb/syncword_hamming_detector_top_tb.sv
`timescale 1ns / 100ps

module syncword_hamming_detector_top_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [syncw_pkg::CNT_W-1:0] COUNT_CAP = 16'hFFFF;

    typedef struct {
        syncw_pkg::item_t   it;
        bit                 typed;
        bit                 has_result;
        syncw_pkg::result_t res;
    } stim_row_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              item_valid;
    logic                              item_stall;
    syncw_pkg::item_t                  item;
    logic                              result_valid;
    logic                              result_stall;
    syncw_pkg::result_t                result;
    logic                              cfg_write;
    syncw_pkg::cfg_index_t             cfg_index;
    logic [syncw_pkg::PATTERN_W-1:0]   cfg_data;

    // predictor copy of configuration and search state
    logic [syncw_pkg::PATTERN_W-1:0] sync_pat;
    logic [syncw_pkg::LEN_W-1:0]     sync_len;
    logic                            lsb_order;
    logic [syncw_pkg::ERR_W-1:0]     err_limit;
    logic [syncw_pkg::PATTERN_W-1:0] win_bits;
    logic [syncw_pkg::CNT_W-1:0]     buf_count;
    bit                              match_made;

    syncw_pkg::result_t expect_q[$];
    stim_row_t          dir_rows[$];
    int                 mismatches;
    int                 idle_cycles;
    int                 active_items;
    int                 predicted_results;
    int                 hold_cycles;
    bit                 quiet;

    syncword_hamming_detector_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int span_bits();
        int n;
        n = int'(sync_len);
        if (n == 0)
            n = 1;
        if (n > 8)
            n = 8;
        return n * 8;
    endfunction

    // sync bit k in the order it arrives on the stream
    function automatic logic sync_bit(input int k);
        int b;
        b = k % 8;
        if (!lsb_order)
            b = 7 - b;
        return sync_pat[(k / 8) * 8 + b];
    endfunction

    function automatic void clear_search();
        win_bits   = '0;
        buf_count  = '0;
        match_made = 1'b0;
    endfunction

    function automatic bit predict_sync(input syncw_pkg::item_t it,
                                        output syncw_pkg::result_t r);
        int len;
        int err_count;
        bit hit;
        hit = 1'b0;
        r   = '0;
        if (it.first_bit)
            clear_search();
        if (!match_made)
        begin
            len = span_bits();
            win_bits = {win_bits[syncw_pkg::PATTERN_W-2:0], it.stream_bit};
            if (buf_count != COUNT_CAP)
                buf_count++;
            if (buf_count >= len)
            begin
                err_count = 0;
                for (int k = 0; k < len; k++)
                    if (win_bits[len - 1 - k] != sync_bit(k))
                        err_count++;
                if (err_count <= err_limit)
                begin
                    hit = 1'b1;
                    r.found = 1'b1;
                    r.end_position = buf_count;
                    match_made = 1'b1;
                end
            end
            if (!hit && it.last_bit)
                hit = 1'b1;
        end
        if (it.last_bit)
            clear_search();
        return hit;
    endfunction

    task automatic send_bit(input syncw_pkg::item_t it, input bit typed, input bit t_has,
                            input syncw_pkg::result_t t_res);
        int gap;
        bit has;
        syncw_pkg::result_t r;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (!match_made || it.first_bit || it.last_bit)
            active_items++;
        has = predict_sync(it, r);
        if (typed)
        begin
            has = t_has;
            r = t_res;
        end
        if (has)
        begin
            expect_q.push_back(r);
            predicted_results++;
        end
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [syncw_pkg::PATTERN_W-1:0] pat,
                              input logic [syncw_pkg::LEN_W-1:0] len,
                              input logic lsb, input logic [syncw_pkg::ERR_W-1:0] errs);
        logic [syncw_pkg::PATTERN_W-1:0] junk;
        junk = {$urandom, $urandom};
        cfg_write <= 1'b1;
        cfg_index <= syncw_pkg::CFG_SYNC_PATTERN;
        cfg_data  <= pat;
        @(posedge clk);
        cfg_index <= syncw_pkg::CFG_SYNC_LEN;
        cfg_data  <= {junk[syncw_pkg::PATTERN_W-1:syncw_pkg::LEN_W], len};
        @(posedge clk);
        cfg_index <= syncw_pkg::CFG_LSB_FIRST;
        cfg_data  <= {junk[syncw_pkg::PATTERN_W-1:1], lsb};
        @(posedge clk);
        cfg_index <= syncw_pkg::CFG_MAX_ERRORS;
        cfg_data  <= {junk[syncw_pkg::PATTERN_W-1:syncw_pkg::ERR_W], errs};
        @(posedge clk);
        cfg_write <= 1'b0;
        sync_pat  = pat;
        sync_len  = len;
        lsb_order = lsb;
        err_limit = errs;
    endtask

    task automatic add_row(input bit b, input bit f, input bit l, input bit typed,
                           input bit has, input bit fnd, input int pos);
        stim_row_t row;
        row.it.stream_bit = b;
        row.it.first_bit = f;
        row.it.last_bit = l;
        row.typed = typed;
        row.has_result = has;
        row.res.found = fnd;
        row.res.end_position = syncw_pkg::CNT_W'(pos);
        dir_rows.push_back(row);
    endtask

    // mostly framed sync words with a few flipped bits, plus noise and cut-off words
    task automatic random_buffer();
        bit               bits[$];
        int               len;
        int               kind;
        int               flips;
        int               n;
        syncw_pkg::item_t it;
        len  = span_bits();
        kind = $urandom_range(0, 9);
        if (kind <= 6)
        begin
            n = $urandom_range(0, 24);
            repeat (n) bits.push_back(1'($urandom_range(0, 1)));
            for (int k = 0; k < len; k++)
                bits.push_back(sync_bit(k));
            flips = $urandom_range(0, (err_limit + 2 > len) ? len : err_limit + 2);
            repeat (flips)
            begin
                n = bits.size() - 1 - $urandom_range(0, len - 1);
                bits[n] = !bits[n];
            end
            n = $urandom_range(0, 12);
            repeat (n) bits.push_back(1'($urandom_range(0, 1)));
        end
        else if (kind == 7)
        begin
            n = $urandom_range(1, 20);
            repeat (n) bits.push_back(1'($urandom_range(0, 1)));
        end
        else
        begin
            n = $urandom_range(0, 4);
            repeat (n) bits.push_back(1'($urandom_range(0, 1)));
            n = $urandom_range(1, len - 1);
            for (int k = 0; k < n; k++)
                bits.push_back(sync_bit(k));
        end
        for (int i = 0; i < bits.size(); i++)
        begin
            it.stream_bit = bits[i];
            it.first_bit = (i == 0) ? ($urandom_range(0, 3) != 0)
                                    : ($urandom_range(0, 199) == 0);
            if (i == bits.size() - 1)
                it.last_bit = (kind == 7) ? 1'($urandom_range(0, 1)) : 1'b1;
            else
                it.last_bit = ($urandom_range(0, 199) == 0);
            send_bit(it, 1'b0, 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int n_items, input int n_results);
        int items0;
        int results0;
        items0 = active_items;
        results0 = predicted_results;
        while (active_items - items0 < n_items || predicted_results - results0 < n_results)
            random_buffer();
    endtask

    // result sink with random stalls and an occasional long hold-off
    initial
    begin : result_sink
        int n;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = quiet ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        syncw_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: found=%0d end_position=%0d",
                             result.found, result.end_position);
            end
            else
            begin
                want = expect_q.pop_front();
                if (want.found !== result.found || want.end_position !== result.end_position)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected found=%0d end_position=%0d,",
                                  " got found=%0d end_position=%0d"},
                                 want.found, want.end_position, result.found,
                                 result.end_position);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : stimulus
        syncw_pkg::item_t                it;
        logic [syncw_pkg::PATTERN_W-1:0] pat;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_write  = 1'b0;
        cfg_index  = syncw_pkg::CFG_SYNC_PATTERN;
        cfg_data   = '0;
        mismatches = 0;
        idle_cycles = 0;
        active_items = 0;
        predicted_results = 0;
        hold_cycles = 0;
        quiet = 1'b0;
        sync_pat  = '0;
        sync_len  = 4'd1;
        lsb_order = 1'b0;
        err_limit = '0;
        clear_search();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset configuration: one byte of zeros, no errors allowed
        add_row(0, 1, 0, 1, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            add_row(0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, 0, 1, 1, 1, 8);
        add_row(1, 0, 1, 1, 0, 0, 0);      // ignored after match, closes buffer
        add_row(1, 1, 1, 1, 1, 0, 0);      // single-bit buffer, no match
        add_row(1, 1, 0, 1, 0, 0, 0);
        add_row(0, 1, 0, 1, 0, 0, 0);      // restart mid-buffer
        for (int i = 0; i < 6; i++)
            add_row(0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, 1, 1, 1, 1, 8);      // match on the last bit
        add_row(1, 0, 0, 0, 0, 0, 0);      // new buffer without first marker
        add_row(0, 0, 1, 0, 0, 0, 0);
        foreach (dir_rows[i])
            send_bit(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].has_result,
                     dir_rows[i].res);
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            pat = {$urandom, $urandom};
            case (ph)
                0: set_config(pat, 4'd1, 1'b0, 7'd0);
                1: set_config(pat, 4'd0, 1'b1, 7'd1);
                2: set_config(pat, 4'd8, 1'b1, 7'd3);
                3: set_config(pat, 4'd15, 1'b0, 7'd64);
                4: set_config(pat, 4'd3, 1'b1, 7'd127);
                5: set_config('1, 4'd2, 1'b0, 7'd2);
                6: set_config('0, 4'd4, 1'b1, 7'd0);
                default: set_config(pat, syncw_pkg::LEN_W'($urandom_range(0, 15)),
                                    1'($urandom_range(0, 1)),
                                    syncw_pkg::ERR_W'($urandom_range(0, 5)));
            endcase
            quiet = (ph == 1);
            run_phase(170, 10);
            quiet = 1'b0;
            if (ph == 3)
            begin
                wait_idle();
                // long hold-off on results while single-bit buffers keep coming
                hold_cycles = 80;
                quiet = 1'b1;
                for (int i = 0; i < 30; i++)
                begin
                    it = '{stream_bit: 1'($urandom_range(0, 1)), first_bit: 1'b1,
                           last_bit: 1'b1};
                    send_bit(it, 1'b0, 1'b0, '0);
                end
                quiet = 1'b0;
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        mismatches += expect_q.size();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
